// ===== rtl/set_assoc_lru_cache_sim_defines.svh =====
// assertion macros used by the checker
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define SACL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sacl check failed");

// next-cycle implication, quiet while reset is held
`define SACL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sacl check failed");

// next-cycle implication that also watches reset itself
`define SACL_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sacl reset check failed");

`endif

// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

    // default geometry limits
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 32;

    // access operations
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_IFETCH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]  hits_added;
        logic        was_miss;
        logic        was_eviction;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } t_out_item;

    // outcome of one set update
    typedef struct packed {
        logic       wr_en;
        logic       miss;
        logic       evict;
        logic [1:0] hits_added;
    } t_lookup;

endpackage

// ===== rtl/sacl_store.sv =====
module sacl_store #(
    parameter int SET_W      = 6,
    parameter int TAG_ROW_W  = 256,
    parameter int META_ROW_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [SET_W-1:0]      i_rd_addr,
    output logic [TAG_ROW_W-1:0]  o_tag_row,
    output logic [META_ROW_W-1:0] o_meta_row,
    input  logic                  i_wr_en,
    input  logic                  i_tag_wr,
    input  logic [SET_W-1:0]      i_wr_addr,
    input  logic [TAG_ROW_W-1:0]  i_tag_row,
    input  logic [META_ROW_W-1:0] i_meta_row
);

    localparam int NUM_SETS = 1 << SET_W;

    logic [TAG_ROW_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [META_ROW_W-1:0] r_meta_mem [NUM_SETS];
    logic [TAG_ROW_W-1:0]  r_tag_rd;
    logic [META_ROW_W-1:0] r_meta_rd;

    // one row per set; the state row is written whole, the tag row only with i_tag_wr
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_meta_mem[i_wr_addr] <= i_meta_row;
            if (i_tag_wr) begin
                r_tag_mem[i_wr_addr] <= i_tag_row;
            end
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_tag_rd  <= r_tag_mem[i_rd_addr];
            r_meta_rd <= r_meta_mem[i_rd_addr];
        end
    end

    assign o_tag_row  = r_tag_rd;
    assign o_meta_row = r_meta_rd;

endmodule

// ===== rtl/sacl_ways.sv =====
module sacl_ways #(
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic [1:0]                                 i_op,
    input  logic [ADDR_WIDTH-1:0]                      i_tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]              i_ways,
    input  logic [MAX_WAYS*ADDR_WIDTH-1:0]             i_tag_row,
    input  logic [MAX_WAYS*(1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] i_meta_row,
    output logic [MAX_WAYS*ADDR_WIDTH-1:0]             o_tag_row,
    output logic [MAX_WAYS*(1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] o_meta_row,
    output sacl_pkg::t_lookup                          o_status
);

    localparam int REC_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam logic [REC_W-1:0] REC_MAX = REC_W'(MAX_WAYS - 1);

    logic [ADDR_WIDTH-1:0] tags    [MAX_WAYS];
    logic [REC_W-1:0]      rec     [MAX_WAYS];
    logic [REC_W-1:0]      new_rec [MAX_WAYS];
    logic [MAX_WAYS-1:0]   valid;
    logic [MAX_WAYS-1:0]   new_valid;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   match;
    logic [MAX_WAYS-1:0]   free;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      lru_idx;
    logic [IDX_W-1:0]      way;
    logic [REC_W-1:0]      limit;
    logic                  hit;
    logic                  fill;
    logic                  fetch;

    // unpack the set row
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i]  = i_tag_row[i*ADDR_WIDTH +: ADDR_WIDTH];
            valid[i] = i_meta_row[i];
            rec[i]   = i_meta_row[MAX_WAYS + i*REC_W +: REC_W];
        end
    end

    // tag compare and free-way search on every way in use
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (WAYS_W'(i) < i_ways);
            match[i]  = in_use[i] && valid[i] && (tags[i] == i_tag);
            free[i]   = in_use[i] && !valid[i];
        end
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (free[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        hit  = |match;
        fill = !hit && (|free);
    end

    // oldest way in use, lowest way on a tie
    always_comb begin
        lru_idx = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && (rec[i] > rec[lru_idx])) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    // recency update around the touched way
    always_comb begin
        if (hit) begin
            way = hit_idx;
        end else if (fill) begin
            way = free_idx;
        end else begin
            way = lru_idx;
        end
        limit     = rec[way];
        new_valid = valid;
        for (int i = 0; i < MAX_WAYS; i++) begin
            new_rec[i] = rec[i];
            if (in_use[i] && (IDX_W'(i) != way) && valid[i] &&
                (fill || (rec[i] < limit)) && (rec[i] < REC_MAX)) begin
                new_rec[i] = rec[i] + REC_W'(1);
            end
        end
        new_rec[way]   = '0;
        new_valid[way] = 1'b1;
    end

    // repack the row
    always_comb begin
        o_tag_row = i_tag_row;
        if (!hit) begin
            o_tag_row[way*ADDR_WIDTH +: ADDR_WIDTH] = i_tag;
        end
        o_meta_row[MAX_WAYS-1:0] = new_valid;
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_meta_row[MAX_WAYS + i*REC_W +: REC_W] = new_rec[i];
        end
    end

    // outcome, fetches leave the set alone
    always_comb begin
        fetch                = (i_op == sacl_pkg::OP_IFETCH);
        o_status.wr_en       = !fetch;
        o_status.miss        = !fetch && !hit;
        o_status.evict       = !fetch && !hit && !fill;
        o_status.hits_added  = fetch ? 2'd0 :
                               (2'((i_op == sacl_pkg::OP_MODIFY) ? 1 : 0) + 2'(hit ? 1 : 0));
    end

endmodule

// ===== rtl/sacl_stats.sv =====
module sacl_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sacl_pkg::t_lookup   i_status,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output sacl_pkg::t_out_item o_out_data,
    output logic                o_free
);

    logic [31:0]         r_hits;
    logic [31:0]         r_misses;
    logic [31:0]         r_evicts;
    logic [31:0]         n_hits;
    logic [31:0]         n_misses;
    logic [31:0]         n_evicts;
    logic [32:0]         hit_sum;
    logic [32:0]         miss_sum;
    logic [32:0]         evict_sum;
    logic                r_out_valid;
    logic                n_out_valid;
    sacl_pkg::t_out_item r_out;

    // output register is free when empty or being taken
    assign o_free = !r_out_valid || !i_out_stall;

    // saturating running totals
    always_comb begin
        hit_sum   = {1'b0, r_hits} + 33'(i_status.hits_added);
        miss_sum  = {1'b0, r_misses} + 33'(i_status.miss);
        evict_sum = {1'b0, r_evicts} + 33'(i_status.evict);
        n_hits    = hit_sum[32] ? '1 : hit_sum[31:0];
        n_misses  = miss_sum[32] ? '1 : miss_sum[31:0];
        n_evicts  = evict_sum[32] ? '1 : evict_sum[31:0];
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_load) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.hits_added      <= i_status.hits_added;
            r_out.was_miss        <= i_status.miss;
            r_out.was_eviction    <= i_status.evict;
            r_out.total_hits      <= n_hits;
            r_out.total_misses    <= n_misses;
            r_out.total_evictions <= n_evicts;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// set-associative cache model with least recently used replacement
// input channel: i_in_valid / o_in_stall carry one access item (operation,
// byte address); it is taken at a clock edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall carry one result item per access
// (hits added, miss and eviction flags, saturating running totals).
// config channel: i_cfg_valid / o_cfg_ready with a register index and data;
// index 0 set bits, 1 block bits, 2 ways in use, other indexes are ignored.
// write config only while no access is in flight.
// the edge that takes an access reads the set row from the tag and state
// memories; in the update step, once the result register is free, an edge
// writes the updated row back and loads the result register, which shows the
// result; a new access is taken only after that write-back.
// the result register decouples the sides: a new access is taken while a
// result waits; a second result waits in the update step until the first
// is taken, and o_in_stall stays high meanwhile.
// after reset a clearing pass walks 2**MAX_SET_BITS rows with o_in_stall
// high; totals and config return to their defaults.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS,
    parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sacl_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sacl_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SET_W      = MAX_SET_BITS;
    localparam int REC_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W     = $clog2(MAX_WAYS + 1);
    localparam int SB_W       = $clog2(MAX_SET_BITS + 1);
    localparam int TAG_ROW_W  = MAX_WAYS * ADDR_WIDTH;
    localparam int META_ROW_W = MAX_WAYS * (1 + REC_W);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [SET_W-1:0]       r_clr_idx;
    logic [2:0]             r_set_bits;
    logic [4:0]             r_block_bits;
    logic [3:0]             r_ways;
    logic [1:0]             r_op;
    logic [ADDR_WIDTH-1:0]  r_tag;
    logic [SET_W-1:0]       r_set;

    logic                   accept;
    logic                   out_free;
    logic                   load;
    logic [63:0]            addr_wide;
    logic [ADDR_WIDTH-1:0]  addr;
    logic [ADDR_WIDTH-1:0]  addr_sh;
    logic [SB_W-1:0]        eff_sb;
    logic [5:0]             shift_amt;
    logic [SET_W-1:0]       set_mask;
    logic [SET_W-1:0]       rd_set;
    logic [ADDR_WIDTH-1:0]  tag;
    logic [WAYS_W-1:0]      eff_ways;

    logic [TAG_ROW_W-1:0]   tag_row_rd;
    logic [META_ROW_W-1:0]  meta_row_rd;
    logic [TAG_ROW_W-1:0]   tag_row_wr;
    logic [META_ROW_W-1:0]  meta_row_upd;
    logic [META_ROW_W-1:0]  meta_row_wr;
    logic                   wr_en;
    logic [SET_W-1:0]       wr_addr;
    sacl_pkg::t_lookup      status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign load        = (r_state == ST_UPD) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sacl_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                sacl_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[4:0];
                sacl_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp geometry to the built limits
    always_comb begin
        if (32'(r_set_bits) > MAX_SET_BITS) begin
            eff_sb = SB_W'(MAX_SET_BITS);
        end else begin
            eff_sb = SB_W'(r_set_bits);
        end
        if (r_ways == 4'd0) begin
            eff_ways = WAYS_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            eff_ways = WAYS_W'(MAX_WAYS);
        end else begin
            eff_ways = WAYS_W'(r_ways);
        end
    end

    // split the address into set index and tag
    always_comb begin
        addr_wide = {32'b0, i_in_data.address};
        addr      = addr_wide[ADDR_WIDTH-1:0];
        addr_sh   = addr >> r_block_bits;
        set_mask  = ~({SET_W{1'b1}} << eff_sb);
        rd_set    = addr_sh[SET_W-1:0] & set_mask;
        shift_amt = 6'(eff_sb) + 6'(r_block_bits);
        if (32'(shift_amt) >= ADDR_WIDTH) begin
            tag = '0;
        end else begin
            tag = addr >> shift_amt;
        end
    end

    // access held for the update step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_data.operation;
            r_tag <= tag;
            r_set <= rd_set;
        end
    end

    // sequencer: clearing pass, then lookup and write-back
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == {SET_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    // write port shared by the clearing pass and the write-back
    always_comb begin
        wr_en       = (r_state == ST_CLEAR) || (load && status.wr_en);
        wr_addr     = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
        meta_row_wr = (r_state == ST_CLEAR) ? '0 : meta_row_upd;
    end

    sacl_store #(
        .SET_W      (SET_W),
        .TAG_ROW_W  (TAG_ROW_W),
        .META_ROW_W (META_ROW_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_set),
        .o_tag_row  (tag_row_rd),
        .o_meta_row (meta_row_rd),
        .i_wr_en    (wr_en),
        .i_tag_wr   (r_state == ST_UPD),
        .i_wr_addr  (wr_addr),
        .i_tag_row  (tag_row_wr),
        .i_meta_row (meta_row_wr)
    );

    sacl_ways #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_ways (
        .i_op       (r_op),
        .i_tag      (r_tag),
        .i_ways     (eff_ways),
        .i_tag_row  (tag_row_rd),
        .i_meta_row (meta_row_rd),
        .o_tag_row  (tag_row_wr),
        .o_meta_row (meta_row_upd),
        .o_status   (status)
    );

    sacl_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_free      (out_free)
    );

endmodule

// ===== rtl/sacl_checker.sv =====
`include "set_assoc_lru_cache_sim_defines.svh"

module sacl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input sacl_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input sacl_pkg::t_out_item             o_out_data,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic hits_ok;

    // a miss adds at most the modify hit, and never more than two hits
    assign hits_ok = (o_out_data.hits_added != 2'd3) &&
                     !(o_out_data.was_miss && (o_out_data.hits_added == 2'd2));

    // a waiting result holds until taken
    `SACL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // an access goes through the update step, so the next one cannot follow at once
    `SACL_ASSERT_NEXT(a_in_gap, i_in_valid && !o_in_stall, o_in_stall)

    // an eviction only happens on a miss
    `SACL_ASSERT_NOW(a_evict_miss, o_out_valid && o_out_data.was_eviction, o_out_data.was_miss)

    // hit count stays in range
    `SACL_ASSERT_NOW(a_hits_range, o_out_valid, hits_ok)

    // reset empties the result register and starts the clearing pass
    `SACL_ASSERT_RST(a_reset_quiet, !i_rst_n, !o_out_valid && o_in_stall)

endmodule

bind set_assoc_lru_cache_sim sacl_checker u_checker (.*);
